@@ src/twg_pkg.sv @@
// Package for the tone waveform generator: shape codes, register indexes,
// field widths and the volume-to-amplitude table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twg_pkg;

  localparam int PERIOD_W = 15;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 17;
  localparam int AMP_W    = 15;
  localparam int SHAPE_W  = 2;
  localparam int VOL_W    = 4;
  localparam int CFG_W    = 4;

  // wave shape codes
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SAWTOOTH = 2'd2;

  // configuration register indexes
  localparam logic CFG_WAVE_SHAPE   = 1'b0;
  localparam logic CFG_VOLUME_LEVEL = 1'b1;

  localparam logic [VOL_W-1:0] VOL_RESET = 4'd5;

  // amplitude = 32767 / (17 - 2*level) for levels 1 to 8; level 0 gives 0, levels above 8 act as 8
  function automatic logic [AMP_W-1:0] vol_to_amp(input logic [VOL_W-1:0] lvl);
    logic [AMP_W-1:0] a;
    case (lvl)
      4'd0: a = 15'd0;
      4'd1: a = 15'd2184;
      4'd2: a = 15'd2520;
      4'd3: a = 15'd2978;
      4'd4: a = 15'd3640;
      4'd5: a = 15'd4681;
      4'd6: a = 15'd6553;
      4'd7: a = 15'd10922;
      default: a = 15'd32767;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ src/tone_waveform_generator_core.sv @@
// Tone waveform generator, top level: phase stepping, shared multiply and a
// radix-4 restoring divider under one sequencer. Depends on twg_pkg.
//
// Input channel (in_valid / in_stall): one beat per audio sample tick, with
//   the note half-period on in_period (0 acts as 1) and a silence flag.
// Output channel (out_valid / out_stall): one signed 16-bit sample on
//   out_sample per input beat.
// Configuration (cfg_we / cfg_index / cfg_wdata): index 0 selects the shape
//   (square, triangle, sawtooth), index 1 the volume level. Write only while idle.
// Sequence: silent beats and the unused shape code go from accept straight to
//   the output stage (S_OUT); square beats take a phase step (S_STEP) first.
//   Triangle and sawtooth beats take a phase step, one 16x15 multiply and a
//   divide over the 30-bit product that retires two quotient bits a cycle
//   (S_STEP, S_MUL, S_DIV, S_FIN, S_OUT). The input is stalled from accept
//   until the result has moved to the output register.
// Reset (rst_n, synchronous, active low) clears the phase counter, held sample
//   and square direction, sets the triangle rising, square shape and volume 5.
// While the receiver stalls, hold the finished sample in the output register;
//   the next beat is still taken and waits at the end of the sequence.
`timescale 1ns / 1ps
`default_nettype none

module tone_waveform_generator_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [twg_pkg::PERIOD_W-1:0]     in_period,
  input  wire                              in_silent,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [twg_pkg::SAMPLE_W-1:0] out_sample,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire  [twg_pkg::CFG_W-1:0]        cfg_wdata
);

  import twg_pkg::*;

  localparam int DIVD_W  = 30;                 // |phase|*amp stays below 2^30
  localparam int STEPS   = DIVD_W / 2;         // two quotient bits per cycle
  localparam int CNT_W   = $clog2(STEPS);
  localparam int EXT_W   = PHASE_W + 1;        // phase arithmetic headroom
  localparam int MAG_W   = SAMPLE_W;           // |phase| <= 32768
  localparam int REM_W   = PERIOD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t                      state_r;
  logic [SHAPE_W-1:0]          shape_r;
  logic [VOL_W-1:0]            vol_r;
  logic signed [PHASE_W-1:0]   phase_r;
  logic                        sq_high_r;
  logic                        tri_up_r;
  logic signed [SAMPLE_W-1:0]  held_r;

  // per-beat working registers
  logic [PERIOD_W-1:0]         per_r;
  logic [SHAPE_W-1:0]          wshape_r;
  logic [AMP_W-1:0]            amp_r;
  logic [MAG_W-1:0]            mag_r;
  logic                        neg_r;
  logic [DIVD_W-1:0]           dq_r;
  logic [REM_W-1:0]            rem_r;
  logic [CNT_W-1:0]            cnt_r;
  logic signed [SAMPLE_W-1:0]  res_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_sample_r;

  // phase step
  logic signed [EXT_W-1:0]     ph_ext, per_ext, ph_nxt;
  logic                        sq_high_nxt, tri_up_nxt;
  logic [EXT_W-1:0]            ph_abs;

  // divider step
  logic [REM_W:0]              r1, r2;
  logic [REM_W-1:0]            r1m, rem_nxt;
  logic                        b1, b2;
  logic [DIVD_W-1:0]           dq_nxt;

  // final scaling
  logic signed [31:0]          q_s, q4;
  logic signed [SAMPLE_W-1:0]  fin_sample;

  logic [2*MAG_W-1:0]          prod;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Advance the shared phase counter for the selected shape.
  always_comb begin
    ph_ext      = EXT_W'(phase_r);
    per_ext     = EXT_W'({1'b0, per_r});
    ph_nxt      = ph_ext;
    sq_high_nxt = sq_high_r;
    tri_up_nxt  = tri_up_r;
    case (wshape_r)
      SHAPE_SQUARE: begin
        if (ph_ext >= per_ext) begin
          ph_nxt      = '0;
          sq_high_nxt = ~sq_high_r;
        end else begin
          ph_nxt = ph_ext + EXT_W'(1);
        end
      end
      SHAPE_TRIANGLE: begin
        if (tri_up_r) begin
          ph_nxt = ph_ext + EXT_W'(2);
          if (ph_nxt >= per_ext) begin
            ph_nxt     = per_ext;
            tri_up_nxt = 1'b0;
          end
        end else begin
          ph_nxt = ph_ext - EXT_W'(2);
          if (ph_nxt <= -per_ext) begin
            ph_nxt     = -per_ext;
            tri_up_nxt = 1'b1;
          end
        end
      end
      SHAPE_SAWTOOTH: begin
        if (ph_ext > per_ext) ph_nxt = -per_ext;
        else                  ph_nxt = ph_ext + EXT_W'(1);
      end
      default: ph_nxt = ph_ext;
    endcase
    ph_abs = ph_nxt[EXT_W-1] ? EXT_W'(-ph_nxt) : EXT_W'(ph_nxt);
  end

  assign prod = {MAG_W'(0), mag_r} * {{(MAG_W-AMP_W){1'b0}}, amp_r};

  // Two restoring divide steps a cycle; quotient bits shift into dq_r.
  always_comb begin
    r1  = {rem_r, dq_r[DIVD_W-1]};
    b1  = (r1 >= {1'b0, per_r});
    r1m = b1 ? REM_W'(r1 - {1'b0, per_r}) : r1[REM_W-1:0];
    r2  = {r1m, dq_r[DIVD_W-2]};
    b2  = (r2 >= {1'b0, per_r});
    rem_nxt = b2 ? REM_W'(r2 - {1'b0, per_r}) : r2[REM_W-1:0];
    dq_nxt  = {dq_r[DIVD_W-3:0], b1, b2};
  end

  // Restore the sign, scale triangle results by four and clip.
  always_comb begin
    q_s = neg_r ? -$signed({2'b0, dq_r}) : $signed({2'b0, dq_r});
    q4  = q_s <<< 2;
    if (wshape_r == SHAPE_TRIANGLE) begin
      if (q4 >= 32'sd32767)       fin_sample = 16'sd32766;
      else if (q4 <= -32'sd32768) fin_sample = -16'sd32767;
      else                        fin_sample = q4[SAMPLE_W-1:0];
    end else begin
      if (q_s > 32'sd32767)       fin_sample = 16'sd32767;
      else if (q_s < -32'sd32768) fin_sample = -16'sd32768;
      else                        fin_sample = q_s[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shape_r     <= SHAPE_SQUARE;
      vol_r       <= VOL_RESET;
      phase_r     <= '0;
      sq_high_r   <= 1'b0;
      tri_up_r    <= 1'b1;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAVE_SHAPE:   shape_r <= cfg_wdata[SHAPE_W-1:0];
          CFG_VOLUME_LEVEL: vol_r   <= cfg_wdata[VOL_W-1:0];
          default: ;
        endcase
      end

      // drop the output beat once taken, unless the next one replaces it
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            per_r    <= (in_period == '0) ? PERIOD_W'(1) : in_period;
            wshape_r <= shape_r;
            amp_r    <= vol_to_amp(vol_r);
            if (in_silent) begin
              res_r   <= (shape_r == SHAPE_TRIANGLE) ? held_r : '0;
              state_r <= S_OUT;
            end else if (shape_r != SHAPE_SQUARE && shape_r != SHAPE_TRIANGLE &&
                         shape_r != SHAPE_SAWTOOTH) begin
              res_r   <= held_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_STEP;
            end
          end
        end
        S_STEP: begin
          phase_r   <= PHASE_W'(ph_nxt);
          sq_high_r <= sq_high_nxt;
          tri_up_r  <= tri_up_nxt;
          mag_r     <= MAG_W'(ph_abs);
          neg_r     <= ph_nxt[EXT_W-1];
          if (wshape_r == SHAPE_SQUARE) begin
            res_r   <= sq_high_nxt ? $signed({1'b0, amp_r}) : -$signed({1'b0, amp_r});
            held_r  <= sq_high_nxt ? $signed({1'b0, amp_r}) : -$signed({1'b0, amp_r});
            state_r <= S_OUT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          dq_r    <= prod[DIVD_W-1:0];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(STEPS - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          res_r   <= fin_sample;
          held_r  <= fin_sample;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_sample_r <= res_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
